[sv/wma_pkg.sv]
// ----------------------------------------------------------------------------
// Whitening matrix apply package
// Shared widths, codes, item types and state encodings of the block.
// ----------------------------------------------------------------------------
package wma_pkg;

    localparam int MAX_CH  = 16;
    localparam int CH_W    = $clog2(MAX_CH);
    localparam int CNT_W   = CH_W + 1;
    localparam int ADDR_W  = 2 * CH_W;
    localparam int COEF_W  = 24;
    localparam int SAMP_W  = 16;
    localparam int PROD_W  = COEF_W + SAMP_W;
    localparam int ACC_W   = 48;
    localparam int RECIP_W = 32;
    localparam int CFG_W   = 32;
    localparam int QP_W    = ACC_W + RECIP_W;

    localparam logic [QP_W:0] Q_HALF = (QP_W + 1)'(1) << 35;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic CFG_CHAN_COUNT  = 1'b0;
    localparam logic CFG_QUANT_RECIP = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [CH_W-1:0]          coeff_row;
        logic [CH_W-1:0]          coeff_col;
        logic signed [COEF_W-1:0] coeff_value;
        logic signed [SAMP_W-1:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]         out_channel;
        logic signed [ACC_W-1:0] result_value;
        logic                    last_of_timepoint;
    } t_out_item;

    typedef struct packed {
        logic               start;
        logic [ACC_W-1:0]   acc;
        logic [RECIP_W-1:0] recip;
    } t_quant_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_EMIT,
        S_QWAIT,
        S_PUT
    } t_state;

    typedef enum logic [2:0] {
        Q_IDLE,
        Q_LO,
        Q_HI,
        Q_SUM,
        Q_RND,
        Q_SAT,
        Q_OUT
    } t_qstate;

endpackage

[sv/wma_coef_ram.sv]
// ----------------------------------------------------------------------------
// Coefficient memory
// Matrix store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module wma_coef_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [wma_pkg::ADDR_W-1:0]    i_waddr,
    input  logic [wma_pkg::COEF_W-1:0]    i_wdata,
    input  logic [wma_pkg::ADDR_W-1:0]    i_raddr,
    output logic [wma_pkg::COEF_W-1:0]    o_rdata
);

    logic [wma_pkg::COEF_W-1:0] r_mem [wma_pkg::MAX_CH * wma_pkg::MAX_CH];
    logic [wma_pkg::COEF_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/wma_quant.sv]
// ----------------------------------------------------------------------------
// Result quantizer
// Scales a Q.20 sum by a Q16.16 reciprocal with one shared 32x32 multiplier,
// adds one half (negative sums: subtracts it), truncates toward zero and saturates to int16.
// ----------------------------------------------------------------------------
module wma_quant (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wma_pkg::t_quant_req        i_req,
    output logic                       o_done,
    output logic [wma_pkg::ACC_W-1:0]  o_result
);

    wma_pkg::t_qstate r_state;
    wma_pkg::t_qstate n_state;

    logic                          r_neg;
    logic [wma_pkg::ACC_W-1:0]     r_mag;
    logic [wma_pkg::RECIP_W-1:0]   r_recip;
    logic [63:0]                   r_p0;
    logic [47:0]                   r_mid;
    logic [wma_pkg::QP_W-1:0]      r_p;
    logic [wma_pkg::QP_W:0]        r_t;
    logic                          r_zero;
    logic [wma_pkg::ACC_W-1:0]     r_res;

    logic [31:0] mul_a;
    logic [63:0] mul_w;
    logic [44:0] q_big;
    logic [16:0] q_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wma_pkg::Q_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        case (r_state)
            wma_pkg::Q_IDLE: begin
                if (i_req.start) begin
                    n_state = wma_pkg::Q_LO;
                end
            end
            wma_pkg::Q_LO:  n_state = wma_pkg::Q_HI;
            wma_pkg::Q_HI:  n_state = wma_pkg::Q_SUM;
            wma_pkg::Q_SUM: n_state = wma_pkg::Q_RND;
            wma_pkg::Q_RND: n_state = wma_pkg::Q_SAT;
            wma_pkg::Q_SAT: n_state = wma_pkg::Q_OUT;
            wma_pkg::Q_OUT: begin
                o_done  = 1'b1;
                n_state = wma_pkg::Q_IDLE;
            end
            default: n_state = wma_pkg::Q_IDLE;
        endcase
    end

    assign mul_a = (r_state == wma_pkg::Q_LO) ? r_mag[31:0] : {16'b0, r_mag[47:32]};
    assign mul_w = mul_a * r_recip;
    assign q_big = r_t[wma_pkg::QP_W:36];

    always_comb begin
        if (!r_neg) begin
            q_sat = (q_big > 45'd32767) ? 17'd32767 : q_big[16:0];
        end else if (r_zero) begin
            q_sat = 17'd0;
        end else begin
            q_sat = (q_big > 45'd32768) ? 17'd32768 : q_big[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            wma_pkg::Q_IDLE: begin
                r_neg   <= i_req.acc[wma_pkg::ACC_W-1];
                r_mag   <= i_req.acc[wma_pkg::ACC_W-1] ? (~i_req.acc + 48'd1) : i_req.acc;
                r_recip <= i_req.recip;
            end
            wma_pkg::Q_LO: r_p0 <= mul_w;
            wma_pkg::Q_HI: r_mid <= mul_w[47:0];
            wma_pkg::Q_SUM: r_p <= {16'b0, r_p0} + {r_mid, 32'b0};
            wma_pkg::Q_RND: begin
                r_zero <= ({1'b0, r_p} <= wma_pkg::Q_HALF);
                if (r_neg) begin
                    r_t <= {1'b0, r_p} - wma_pkg::Q_HALF;
                end else begin
                    r_t <= {1'b0, r_p} + wma_pkg::Q_HALF;
                end
            end
            wma_pkg::Q_SAT: begin
                if (r_neg) begin
                    r_res <= 48'd0 - {31'b0, q_sat};
                end else begin
                    r_res <= {31'b0, q_sat};
                end
            end
            default: ;
        endcase
    end

    assign o_result = r_res;

endmodule

[sv/whitening_matrix_apply_top.sv]
// ----------------------------------------------------------------------------
// Whitening matrix apply
// Multiplies a loaded coefficient matrix with channel-serial sample vectors.
// ----------------------------------------------------------------------------
// Input items either load one coefficient or bring the next channel sample.
// A load is written while the block stays idle. A sample runs one
// multiply-accumulate per used output channel through the shared MAC
// pipeline. With n used channels, the block takes no new item until all n
// multiply-accumulates of a sample are done and any results are issued.
// The sample that completes a timepoint is followed by n result items in
// channel order, the last one flagged. When quantization is on, each result
// passes through the quantizer, whose shared multiplier works in two passes.
// A result waits in the output register while the receiver stalls, and the
// sequencer holds until that register is free.
// Configuration writes take effect at once and must only be made while the
// block is idle. Reset clears the accumulators, the sample position and the
// output register, sets channel_count to 16 and turns quantization off; the
// coefficient memory holds no defined value until written.
// ----------------------------------------------------------------------------
module whitening_matrix_apply_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  wma_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output wma_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [wma_pkg::CFG_W-1:0]  i_cfg_data
);

    wma_pkg::t_state r_state;
    wma_pkg::t_state n_state;

    logic [wma_pkg::CNT_W-1:0]    r_chan_cnt;
    logic [wma_pkg::RECIP_W-1:0]  r_recip;
    logic [wma_pkg::CNT_W-1:0]    n_used;

    logic [wma_pkg::CH_W-1:0]     r_pos;
    logic [wma_pkg::CH_W-1:0]     r_col;
    logic signed [wma_pkg::SAMP_W-1:0] r_sample;
    logic [wma_pkg::CNT_W-1:0]    r_rd_row;
    logic                         r_v1;
    logic                         r_v2;
    logic [wma_pkg::CH_W-1:0]     r_row1;
    logic [wma_pkg::CH_W-1:0]     r_row2;
    logic signed [wma_pkg::PROD_W-1:0] r_prod;

    logic [wma_pkg::ACC_W-1:0]    r_acc [wma_pkg::MAX_CH];
    logic [wma_pkg::MAX_CH-1:0]   r_acc_vld;
    logic [wma_pkg::CH_W-1:0]     r_out_row;
    logic [wma_pkg::ACC_W-1:0]    r_res;

    logic                         r_out_vld;
    wma_pkg::t_out_item           r_out_item;

    logic                         in_acc;
    logic                         issue;
    logic                         mac_done;
    logic                         ends_tp;
    logic                         out_free;
    logic                         last_row;
    logic [wma_pkg::ACC_W-1:0]    emit_acc;
    logic [wma_pkg::ACC_W-1:0]    acc_base;
    logic [wma_pkg::COEF_W-1:0]   ram_rdata;
    logic                         ram_we;
    wma_pkg::t_quant_req          q_req;
    logic                         q_done;
    logic [wma_pkg::ACC_W-1:0]    q_result;

    always_comb begin
        if (r_chan_cnt == '0) begin
            n_used = wma_pkg::CNT_W'(1);
        end else if (r_chan_cnt > wma_pkg::CNT_W'(wma_pkg::MAX_CH)) begin
            n_used = wma_pkg::CNT_W'(wma_pkg::MAX_CH);
        end else begin
            n_used = r_chan_cnt;
        end
    end

    assign in_acc   = i_in_valid && o_in_ready;
    assign ram_we   = in_acc && (i_in_item.action == wma_pkg::ACT_LOAD);
    assign issue    = (r_rd_row < n_used);
    assign mac_done = !issue && !r_v1 && !r_v2;
    assign ends_tp  = ({1'b0, r_col} + wma_pkg::CNT_W'(1)) >= n_used;
    assign out_free = !r_out_vld || i_out_ready;
    assign last_row = ({1'b0, r_out_row} + wma_pkg::CNT_W'(1)) == n_used;
    assign emit_acc = r_acc_vld[r_out_row] ? r_acc[r_out_row] : '0;
    assign acc_base = r_acc_vld[r_row2] ? r_acc[r_row2] : '0;

    wma_coef_ram u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({i_in_item.coeff_row, i_in_item.coeff_col}),
        .i_wdata (i_in_item.coeff_value),
        .i_raddr ({r_rd_row[wma_pkg::CH_W-1:0], r_col}),
        .o_rdata (ram_rdata)
    );

    wma_quant u_quant (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (q_req),
        .o_done   (q_done),
        .o_result (q_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wma_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        q_req.start = 1'b0;
        q_req.acc   = emit_acc;
        q_req.recip = r_recip;
        case (r_state)
            wma_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_in_item.action == wma_pkg::ACT_SAMPLE) begin
                    n_state = wma_pkg::S_MAC;
                end
            end
            wma_pkg::S_MAC: begin
                if (mac_done) begin
                    n_state = ends_tp ? wma_pkg::S_EMIT : wma_pkg::S_IDLE;
                end
            end
            wma_pkg::S_EMIT: begin
                if (r_recip == '0) begin
                    n_state = wma_pkg::S_PUT;
                end else begin
                    q_req.start = 1'b1;
                    n_state     = wma_pkg::S_QWAIT;
                end
            end
            wma_pkg::S_QWAIT: begin
                if (q_done) begin
                    n_state = wma_pkg::S_PUT;
                end
            end
            wma_pkg::S_PUT: begin
                if (out_free) begin
                    n_state = last_row ? wma_pkg::S_IDLE : wma_pkg::S_EMIT;
                end
            end
            default: n_state = wma_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= wma_pkg::CNT_W'(wma_pkg::MAX_CH);
            r_recip    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wma_pkg::CFG_CHAN_COUNT:  r_chan_cnt <= i_cfg_data[wma_pkg::CNT_W-1:0];
                wma_pkg::CFG_QUANT_RECIP: r_recip <= i_cfg_data[wma_pkg::RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_rd_row  <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_acc_vld <= '0;
            r_out_row <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_out_ready && !(r_state == wma_pkg::S_PUT && out_free)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                wma_pkg::S_IDLE: begin
                    r_v1 <= 1'b0;
                    r_v2 <= 1'b0;
                    if (in_acc && i_in_item.action == wma_pkg::ACT_SAMPLE) begin
                        r_sample <= i_in_item.sample_value;
                        r_col    <= r_pos;
                        r_rd_row <= '0;
                    end
                end
                wma_pkg::S_MAC: begin
                    r_v1   <= issue;
                    r_row1 <= r_rd_row[wma_pkg::CH_W-1:0];
                    if (issue) begin
                        r_rd_row <= r_rd_row + wma_pkg::CNT_W'(1);
                    end
                    r_v2   <= r_v1;
                    r_row2 <= r_row1;
                    r_prod <= $signed(ram_rdata) * r_sample;
                    if (r_v2) begin
                        r_acc[r_row2] <= acc_base
                            + {{(wma_pkg::ACC_W - wma_pkg::PROD_W){r_prod[wma_pkg::PROD_W-1]}},
                               r_prod};
                        r_acc_vld[r_row2] <= 1'b1;
                    end
                    if (mac_done) begin
                        r_out_row <= '0;
                        r_pos     <= ends_tp ? '0 : r_col + wma_pkg::CH_W'(1);
                    end
                end
                wma_pkg::S_EMIT: begin
                    r_res <= emit_acc;
                end
                wma_pkg::S_QWAIT: begin
                    if (q_done) begin
                        r_res <= q_result;
                    end
                end
                wma_pkg::S_PUT: begin
                    if (out_free) begin
                        r_out_vld                     <= 1'b1;
                        r_out_item.out_channel        <= r_out_row;
                        r_out_item.result_value       <= r_res;
                        r_out_item.last_of_timepoint  <= last_row;
                        if (last_row) begin
                            r_acc_vld <= '0;
                        end else begin
                            r_out_row <= r_out_row + wma_pkg::CH_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Whitening matrix apply testbench
// Loads the full coefficient matrix, walks a table of directed steps, then
// runs random sample and load items under changing channel counts and
// quantization scales. A predictor follows every accepted item and each
// result item is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int SETTLE_CYCLES = 40;
    localparam logic [wma_pkg::QP_W:0] ROUND_HALF = (wma_pkg::QP_W + 1)'(1) << 35;
    localparam logic [wma_pkg::QP_W:0] POS_LIMIT  = (wma_pkg::QP_W + 1)'(32767);
    localparam logic [wma_pkg::QP_W:0] NEG_LIMIT  = (wma_pkg::QP_W + 1)'(32768);

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_LOAD,
        STEP_SAMPLE
    } t_step_kind;

    typedef struct packed {
        t_step_kind                        kind;
        logic                              cfg_idx;
        logic [wma_pkg::CFG_W-1:0]         cfg_data;
        logic [wma_pkg::CH_W-1:0]          row;
        logic [wma_pkg::CH_W-1:0]          col;
        logic signed [wma_pkg::COEF_W-1:0] coef;
        logic signed [wma_pkg::SAMP_W-1:0] samp;
        logic                              known;
        logic signed [wma_pkg::ACC_W-1:0]  want;
    } t_step;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    wma_pkg::t_in_item         in_item = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    wma_pkg::t_out_item        out_item;
    logic                      cfg_we = 1'b0;
    logic                      cfg_idx = wma_pkg::CFG_CHAN_COUNT;
    logic [wma_pkg::CFG_W-1:0] cfg_data = '0;

    int send_gap_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;

    logic signed [wma_pkg::COEF_W-1:0] coef_mem [wma_pkg::MAX_CH][wma_pkg::MAX_CH];
    logic [wma_pkg::ACC_W-1:0]         row_acc [wma_pkg::MAX_CH];
    int                                col_pos = 0;
    logic [wma_pkg::CNT_W-1:0]         chan_count = 5'd16;
    logic [wma_pkg::RECIP_W-1:0]       recip = '0;
    wma_pkg::t_out_item                mixed_results [$];
    wma_pkg::t_out_item                head_result;
    t_step                             plan [31];

    whitening_matrix_apply_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [wma_pkg::ACC_W-1:0] quantize_q20(
        input logic [wma_pkg::ACC_W-1:0]   sum,
        input logic [wma_pkg::RECIP_W-1:0] scale);
        logic [wma_pkg::ACC_W:0]  mag;
        logic [wma_pkg::QP_W:0]   scaled;
        logic [wma_pkg::QP_W:0]   whole;
        if (sum[wma_pkg::ACC_W-1]) begin
            mag = {1'b1, {wma_pkg::ACC_W{1'b0}}} - {1'b0, sum};
        end else begin
            mag = {1'b0, sum};
        end
        scaled = mag * scale;
        if (!sum[wma_pkg::ACC_W-1]) begin
            whole = (scaled + ROUND_HALF) >> 36;
            if (whole > POS_LIMIT) whole = POS_LIMIT;
            return whole[wma_pkg::ACC_W-1:0];
        end
        if (scaled <= ROUND_HALF) return '0;
        whole = (scaled - ROUND_HALF) >> 36;
        if (whole > NEG_LIMIT) whole = NEG_LIMIT;
        return '0 - whole[wma_pkg::ACC_W-1:0];
    endfunction

    function automatic void mix_sample(input logic signed [wma_pkg::SAMP_W-1:0] samp,
                                       input logic known,
                                       input logic signed [wma_pkg::ACC_W-1:0] want);
        int                               n;
        int                               c;
        int                               r;
        logic signed [wma_pkg::ACC_W-1:0] prod;
        wma_pkg::t_out_item               res;
        n = (chan_count == 0) ? 1 :
            (chan_count > wma_pkg::MAX_CH) ? wma_pkg::MAX_CH : int'(chan_count);
        c = (col_pos >= wma_pkg::MAX_CH) ? wma_pkg::MAX_CH - 1 : col_pos;
        for (r = 0; r < n; r++) begin
            prod = coef_mem[r][c] * samp;
            row_acc[r] = row_acc[r] + prod;
        end
        col_pos = c + 1;
        if (col_pos >= n) begin
            for (r = 0; r < n; r++) begin
                res.out_channel = wma_pkg::CH_W'(r);
                res.result_value = (recip == 0) ? row_acc[r] : quantize_q20(row_acc[r], recip);
                if (known) res.result_value = want;
                res.last_of_timepoint = (r == n - 1);
                mixed_results.push_back(res);
            end
            for (r = 0; r < wma_pkg::MAX_CH; r++) row_acc[r] = '0;
            col_pos = 0;
        end
    endfunction

    function automatic wma_pkg::t_in_item random_item(input logic act);
        logic [63:0]       bits;
        wma_pkg::t_in_item it;
        bits = {$urandom, $urandom};
        it = bits[$bits(wma_pkg::t_in_item)-1:0];
        it.action = act;
        if ($urandom_range(9) < 7) it.coeff_value = it.coeff_value >>> $urandom_range(0, 12);
        if ($urandom_range(9) == 0) it.coeff_value = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
        if ($urandom_range(9) < 3) it.sample_value = it.sample_value >>> $urandom_range(0, 8);
        if ($urandom_range(9) == 0) it.sample_value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        return it;
    endfunction

    function automatic t_step step_cfg(input logic idx, input logic [wma_pkg::CFG_W-1:0] data);
        t_step s;
        s = '0;
        s.kind = STEP_CFG;
        s.cfg_idx = idx;
        s.cfg_data = data;
        return s;
    endfunction

    function automatic t_step step_load(input int r, input int c,
                                        input logic signed [wma_pkg::COEF_W-1:0] v);
        t_step s;
        s = '0;
        s.kind = STEP_LOAD;
        s.row = wma_pkg::CH_W'(r);
        s.col = wma_pkg::CH_W'(c);
        s.coef = v;
        return s;
    endfunction

    function automatic t_step step_samp(input logic signed [wma_pkg::SAMP_W-1:0] v,
                                        input logic known,
                                        input logic signed [wma_pkg::ACC_W-1:0] want);
        t_step s;
        s = '0;
        s.kind = STEP_SAMPLE;
        s.samp = v;
        s.known = known;
        s.want = want;
        return s;
    endfunction

    task automatic send_item(input wma_pkg::t_in_item it, input logic known,
                             input logic signed [wma_pkg::ACC_W-1:0] want);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        if (it.action == wma_pkg::ACT_LOAD) begin
            coef_mem[it.coeff_row][it.coeff_col] = it.coeff_value;
        end else begin
            mix_sample(it.sample_value, known, want);
        end
    endtask

    task automatic wait_quiet();
        while (mixed_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [wma_pkg::CFG_W-1:0] data);
        in_valid <= 1'b0;
        wait_quiet();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == wma_pkg::CFG_CHAN_COUNT) begin
            chan_count = data[wma_pkg::CNT_W-1:0];
        end else begin
            recip = data;
        end
    endtask

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (mixed_results.size() == 0) begin
                $display("%0t: unexpected result, channel %0d value %0d",
                         $time, out_item.out_channel, $signed(out_item.result_value));
                mismatches++;
            end else begin
                head_result = mixed_results.pop_front();
                if (out_item.out_channel !== head_result.out_channel) begin
                    $display("%0t: out_channel expected %0d, got %0d", $time,
                             head_result.out_channel, out_item.out_channel);
                    mismatches++;
                end
                if (out_item.result_value !== head_result.result_value) begin
                    $display("%0t: result_value of channel %0d expected %0d, got %0d",
                             $time, head_result.out_channel,
                             $signed(head_result.result_value),
                             $signed(out_item.result_value));
                    mismatches++;
                end
                if (out_item.last_of_timepoint !== head_result.last_of_timepoint) begin
                    $display("%0t: last_of_timepoint of channel %0d expected %0b, got %0b",
                             $time, head_result.out_channel,
                             head_result.last_of_timepoint, out_item.last_of_timepoint);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        wma_pkg::t_in_item         it;
        int                        sent;
        int                        seg;
        logic [wma_pkg::CNT_W-1:0] cnt;
        logic [wma_pkg::CFG_W-1:0] scale;

        for (int r = 0; r < wma_pkg::MAX_CH; r++) row_acc[r] = '0;
        send_gap_pct = 8;
        stall_pct = 57;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every coefficient is written before the first sample reads the matrix.
        for (int r = 0; r < wma_pkg::MAX_CH; r++) begin
            for (int c = 0; c < wma_pkg::MAX_CH; c++) begin
                it = random_item(wma_pkg::ACT_LOAD);
                it.coeff_row = wma_pkg::CH_W'(r);
                it.coeff_col = wma_pkg::CH_W'(c);
                send_item(it, 1'b0, '0);
            end
        end

        plan = '{
            step_cfg(wma_pkg::CFG_CHAN_COUNT, 32'd1),
            step_load(0, 0, 24'sh100000),
            step_samp(16'sd5, 1'b1, 48'sd5242880),
            step_samp(-16'sd32768, 1'b1, -48'sd34359738368),
            step_load(0, 0, -24'sd8388608),
            step_samp(-16'sd32768, 1'b1, 48'sd274877906944),
            step_samp(16'sd32767, 1'b1, -48'sd274869518336),
            step_load(0, 0, 24'sd8388607),
            step_samp(16'sd32767, 1'b1, 48'sd274869485569),
            step_samp(-16'sd32768, 1'b1, -48'sd274877874176),
            step_cfg(wma_pkg::CFG_QUANT_RECIP, 32'd65536),
            step_samp(16'sd32767, 1'b1, 48'sd32767),
            step_samp(-16'sd32768, 1'b1, -48'sd32768),
            step_load(0, 0, 24'sh080000),
            step_samp(16'sd1, 1'b1, 48'sd1),
            step_samp(-16'sd1, 1'b1, 48'sd0),
            step_samp(16'sd3, 1'b1, 48'sd2),
            step_samp(-16'sd3, 1'b1, -48'sd1),
            step_samp(16'sd0, 1'b1, 48'sd0),
            step_cfg(wma_pkg::CFG_QUANT_RECIP, 32'hFFFF_FFFF),
            step_samp(16'sd1, 1'b1, 48'sd32767),
            step_samp(-16'sd2, 1'b1, -48'sd32768),
            step_cfg(wma_pkg::CFG_CHAN_COUNT, 32'd0),
            step_samp(16'sd7, 1'b1, 48'sd32767),
            step_cfg(wma_pkg::CFG_QUANT_RECIP, 32'd0),
            step_load(15, 15, 24'sh7ABCDE),
            step_cfg(wma_pkg::CFG_CHAN_COUNT, 32'd4),
            step_samp(16'sd100, 1'b0, '0),
            step_samp(-16'sd200, 1'b0, '0),
            step_cfg(wma_pkg::CFG_CHAN_COUNT, 32'd2),
            step_samp(16'sd300, 1'b0, '0)
        };

        foreach (plan[i]) begin
            case (plan[i].kind)
                STEP_CFG: begin
                    write_reg(plan[i].cfg_idx, plan[i].cfg_data);
                end
                default: begin
                    it = '0;
                    it.action = (plan[i].kind == STEP_SAMPLE) ?
                                wma_pkg::ACT_SAMPLE : wma_pkg::ACT_LOAD;
                    it.coeff_row = plan[i].row;
                    it.coeff_col = plan[i].col;
                    it.coeff_value = plan[i].coef;
                    it.sample_value = plan[i].samp;
                    send_item(it, plan[i].known, plan[i].want);
                end
            endcase
        end

        for (int mode = 0; mode < 3; mode++) begin
            send_gap_pct = (mode == 0) ? 8 : (mode == 1) ? 57 : 0;
            stall_pct = (mode == 0) ? 57 : (mode == 1) ? 8 : 0;
            sent = 0;
            while (sent < 48) begin
                if ($urandom_range(9) < 7) begin
                    case ($urandom_range(7))
                        0: cnt = 5'd0;
                        1: cnt = 5'd1;
                        2: cnt = 5'd16;
                        3: cnt = 5'd31;
                        4: cnt = 5'd17;
                        default: cnt = wma_pkg::CNT_W'($urandom_range(2, 15));
                    endcase
                    if ($urandom_range(1)) begin
                        write_reg(wma_pkg::CFG_CHAN_COUNT, {27'($urandom >> 5), cnt});
                    end else begin
                        write_reg(wma_pkg::CFG_CHAN_COUNT, {27'd0, cnt});
                    end
                end
                if ($urandom_range(1)) begin
                    case ($urandom_range(7))
                        0, 1: scale = '0;
                        2: scale = 32'd65536;
                        3: scale = $urandom_range(1, 4096);
                        4: scale = 32'hFFFF_FFFF;
                        5: scale = 32'd1;
                        default: scale = $urandom;
                    endcase
                    write_reg(wma_pkg::CFG_QUANT_RECIP, scale);
                end
                seg = $urandom_range(4, 16);
                repeat (seg) begin
                    send_item(random_item($urandom_range(99) >= 12), 1'b0, '0);
                    sent++;
                end
            end
        end

        in_valid <= 1'b0;
        wait_quiet();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
sv/wma_pkg.sv
sv/wma_coef_ram.sv
sv/wma_quant.sv
sv/whitening_matrix_apply_top.sv
tb/sv/tb.sv
